>>> rtl/bplc_pkg.sv
// Shared constants, types and helpers for the button press LED blink controller.
package bplc_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W    = 16;
	localparam int BTN_W    = 8;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		REG_SHORT    = 2'd0,
		REG_LONG     = 2'd1,
		REG_PERIOD   = 2'd2,
		REG_DURATION = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] short_ticks;
		logic [CNT_W-1:0] long_ticks;
		logic [CNT_W-1:0] period_ticks;
		logic [CNT_W-1:0] duration_ticks;
		logic             period_wr;
	} cfg_t;

	// Per-channel state word; phase tracks blink_count modulo the blink period.
	typedef struct packed {
		logic [CNT_W-1:0] press;
		logic [CNT_W-1:0] blink;
		logic [CNT_W-1:0] phase;
		logic             flag;
		logic             led;
	} chan_state_t;

	function automatic logic [CNT_W-1:0] eff_period(input logic [CNT_W-1:0] p);
		eff_period = (p == '0) ? CNT_W'(1) : p;
	endfunction

endpackage

>>> rtl/bplc_cfg_regs.sv
// APB register file holding the press thresholds and blink timing.
module bplc_cfg_regs
	import bplc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [CNT_W-1:0] short_q, long_q, period_q, duration_q;
	logic             period_wr_q;
	logic             wr;
	reg_idx_t         idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q     <= CNT_W'(5);
			long_q      <= CNT_W'(100);
			period_q    <= CNT_W'(25);
			duration_q  <= CNT_W'(500);
			period_wr_q <= 1'b0;
		end else begin
			period_wr_q <= 1'b0;
			if (wr) begin
				unique case (idx)
					REG_SHORT:    short_q    <= pwdata[CNT_W-1:0];
					REG_LONG:     long_q     <= pwdata[CNT_W-1:0];
					REG_PERIOD: begin
						period_q    <= pwdata[CNT_W-1:0];
						period_wr_q <= 1'b1;
					end
					REG_DURATION: duration_q <= pwdata[CNT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_SHORT:    prdata = APB_DW'(short_q);
			REG_LONG:     prdata = APB_DW'(long_q);
			REG_PERIOD:   prdata = APB_DW'(period_q);
			REG_DURATION: prdata = APB_DW'(duration_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.short_ticks    = short_q;
	assign cfg.long_ticks     = long_q;
	assign cfg.period_ticks   = period_q;
	assign cfg.duration_ticks = duration_q;
	assign cfg.period_wr      = period_wr_q;

endmodule

>>> rtl/bplc_chan_mem.sv
// Channel state memory with registered read and per-entry valid bits.
module bplc_chan_mem
	import bplc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [CH_W-1:0] rd_addr,
	output chan_state_t     rd_data,
	input  logic            wr_en,
	input  logic [CH_W-1:0] wr_addr,
	input  chan_state_t     wr_data
);

	chan_state_t         mem [CHANNELS];
	chan_state_t         rd_data_q;
	logic [CHANNELS-1:0] vld_q;
	logic                rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// An entry never written since reset reads as all zeros.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

>>> rtl/bplc_rem_div.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module bplc_rem_div
	import bplc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CNT_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [CNT_W-1:0] rem
);

	localparam int STEP_W = $clog2(CNT_W);

	logic [CNT_W-1:0]  r_q, d_q, p_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q, done_q;
	logic [CNT_W:0]    trial;

	assign trial = {r_q, d_q[CNT_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(CNT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			d_q <= dividend;
			p_q <= divisor;
		end else if (busy_q) begin
			d_q <= {d_q[CNT_W-2:0], 1'b0};
			if (trial >= {1'b0, p_q}) begin
				r_q <= CNT_W'(trial - {1'b0, p_q});
			end else begin
				r_q <= trial[CNT_W-1:0];
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = r_q;

endmodule

>>> rtl/button_press_led_blink_controller_core.sv
// Top level: tick sequencer over the channel state memory, phase resync and result register.
//
//   channel   direction  handshake             beat payload
//   in        in         in_valid / in_stall   button_levels
//   out       out        out_valid / out_stall led_levels, blink_active
//   cfg       in         APB write/read        short, long, period, duration
//
// A tick runs through one memory read per channel, the read-modify-write of the last channel,
// the load of the result register once the output is free, then the idle state that takes
// the next beat. A write to the blink period queues a resync of every channel's blink phase
// in the serial remainder unit, run once the sequencer is idle; ticks stall meanwhile.
// Reset clears all channel state at once through the memory's valid bits.
// A tick may be accepted while the previous result still waits under out_stall.
module button_press_led_blink_controller_core
	import bplc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BTN_W-1:0]  button_levels,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BTN_W-1:0]  led_levels,
	output logic [BTN_W-1:0]  blink_active,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE,
		ST_SW_RD,
		ST_SW_LD,
		ST_SW_DIV
	} state_t;

	state_t           state_q;
	cfg_t             cfg;
	logic [CH_W:0]    iss_q;
	logic             vld_s1;
	logic [CH_W-1:0]  ch_s1;
	logic [CH_W-1:0]  sw_ch_q;
	logic             sweep_req_q;
	logic [BTN_W-1:0] levels_q;
	logic [BTN_W-1:0] led_acc_q, blk_acc_q;
	logic [BTN_W-1:0] led_out_q, blk_out_q;
	logic             out_valid_q;
	chan_state_t      sw_ent_q;

	logic             rd_en, wr_en;
	logic [CH_W-1:0]  rd_addr, wr_addr;
	chan_state_t      rd_data, wr_data, upd;
	logic             div_start, div_busy, div_done;
	logic [CNT_W-1:0] div_rem;
	logic [CNT_W-1:0] per;
	logic [4:0]       ch5;
	logic             held;
	logic             issuing;

	bplc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bplc_chan_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	bplc_rem_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_data.blink),
		.divisor  (per),
		.busy     (div_busy),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign per     = eff_period(cfg.period_ticks);
	assign issuing = (state_q == ST_RUN) && (iss_q < (CH_W+1)'(CHANNELS));
	assign rd_en   = issuing || (state_q == ST_SW_RD);
	assign rd_addr = (state_q == ST_RUN) ? iss_q[CH_W-1:0] : sw_ch_q;

	assign div_start = (state_q == ST_SW_LD);
	assign ch5       = 5'(ch_s1);
	assign held      = (ch5 < 5'd8) && levels_q[ch5[2:0]];

	// Per-channel update for one tick; phase stands in for blink_count mod period.
	always_comb begin
		upd = rd_data;
		if (rd_data.flag) begin
			if (rd_data.blink != CNT_MAX) begin
				upd.blink = rd_data.blink + CNT_W'(1);
				if ((CNT_W+1)'(rd_data.phase) + (CNT_W+1)'(1) == (CNT_W+1)'(per)) begin
					upd.phase = '0;
				end else begin
					upd.phase = rd_data.phase + CNT_W'(1);
				end
			end
			if (upd.phase == '0) begin
				upd.led = ~rd_data.led;
			end
			if (upd.blink >= cfg.duration_ticks) begin
				upd.flag = 1'b0;
			end
		end else if (held) begin
			if (rd_data.press != CNT_MAX) begin
				upd.press = rd_data.press + CNT_W'(1);
			end
		end else begin
			if (rd_data.press < cfg.short_ticks) begin
				upd.led = rd_data.led;
			end else if (rd_data.press < cfg.long_ticks) begin
				upd.led = ~rd_data.led;
			end else begin
				upd.flag  = 1'b1;
				upd.blink = '0;
				upd.phase = '0;
			end
			upd.press = '0;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ch_s1;
		wr_data = upd;
		if (state_q == ST_RUN && vld_s1) begin
			wr_en = 1'b1;
		end else if (state_q == ST_SW_DIV && div_done) begin
			wr_en         = 1'b1;
			wr_addr       = sw_ch_q;
			wr_data       = sw_ent_q;
			wr_data.phase = div_rem;
		end
	end

	always_ff @(posedge clk) begin
		ch_s1 <= iss_q[CH_W-1:0];
		if (state_q == ST_SW_LD) begin
			sw_ent_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iss_q       <= '0;
			vld_s1      <= 1'b0;
			sw_ch_q     <= '0;
			sweep_req_q <= 1'b0;
			levels_q    <= '0;
			led_acc_q   <= '0;
			blk_acc_q   <= '0;
			led_out_q   <= '0;
			blk_out_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= issuing;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sweep_req_q) begin
						sweep_req_q <= 1'b0;
						sw_ch_q     <= '0;
						state_q     <= ST_SW_RD;
					end else if (in_valid && !cfg.period_wr) begin
						levels_q  <= button_levels;
						iss_q     <= '0;
						led_acc_q <= '0;
						blk_acc_q <= '0;
						state_q   <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (issuing) begin
						iss_q <= iss_q + (CH_W+1)'(1);
					end
					if (vld_s1) begin
						if (ch5 < 5'd8) begin
							led_acc_q[ch5[2:0]] <= upd.led;
							blk_acc_q[ch5[2:0]] <= upd.flag;
						end
						if (ch_s1 == CH_W'(CHANNELS - 1)) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						led_out_q   <= led_acc_q;
						blk_out_q   <= blk_acc_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_SW_RD: state_q <= ST_SW_LD;
				ST_SW_LD: state_q <= ST_SW_DIV;
				ST_SW_DIV: begin
					if (div_done) begin
						if (sw_ch_q == CH_W'(CHANNELS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							sw_ch_q <= sw_ch_q + CH_W'(1);
							state_q <= ST_SW_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// A period write during a resync restarts it once the current pass ends.
			if (cfg.period_wr) begin
				sweep_req_q <= 1'b1;
			end
		end
	end

	// The cycle right after a period write already stalls, before the resync request is seen.
	assign in_stall     = (state_q != ST_IDLE) || sweep_req_q || cfg.period_wr;
	assign out_valid    = out_valid_q;
	assign led_levels   = led_out_q;
	assign blink_active = blk_out_q;

`ifndef SYNTHESIS
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr_en |-> rd_addr != wr_addr)
		else $error("channel memory read and write hit the same entry");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("remainder unit restarted while busy");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the done state");

	a_accept_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_RUN && iss_q == '0)
		else $error("accepted tick did not start a channel pass");
`endif

endmodule

>>> dv/tb_button_press_led_blink_controller_core.sv
// Self-checking testbench for the button press LED blink controller core.
module tb_button_press_led_blink_controller_core
	import bplc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500_000;

	typedef struct packed {
		logic [BTN_W-1:0] leds;
		logic [BTN_W-1:0] blinks;
	} tick_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [BTN_W-1:0]  button_levels = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [BTN_W-1:0]  led_levels;
	logic [BTN_W-1:0]  blink_active;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	button_press_led_blink_controller_core DUT (.*);

	always #5 clk = ~clk;

	// Local copy of the thresholds and of every channel's state.
	logic [CNT_W-1:0] short_thr = 16'd5;
	logic [CNT_W-1:0] long_thr = 16'd100;
	logic [CNT_W-1:0] period_thr = 16'd25;
	logic [CNT_W-1:0] duration_thr = 16'd500;
	logic [CNT_W-1:0] press_ticks [CHANNELS] = '{default: '0};
	logic [CNT_W-1:0] blink_ticks [CHANNELS] = '{default: '0};
	logic             blinking [CHANNELS] = '{default: 1'b0};
	logic             led_on [CHANNELS] = '{default: 1'b0};

	logic [BTN_W-1:0] tick_queue [$];
	tick_result_t     mask_expect_q [$];
	int               mismatches = 0;
	int               cycles = 0;
	int               gap_pct = 0;
	int               stall_pct = 0;
	int               send_gap = 0;
	int               stall_left = 0;
	int               hold_left [BTN_W] = '{default: 0};
	int               rest_left [BTN_W] = '{default: 0};

	function automatic tick_result_t predict_tick(input logic [BTN_W-1:0] levels);
		tick_result_t     r;
		logic [CNT_W-1:0] per;
		logic             held;
		r = '0;
		per = period_thr;
		if (per == '0) begin
			per = CNT_W'(1);
		end
		for (int ch = 0; ch < CHANNELS; ch++) begin
			held = (ch < BTN_W) ? levels[ch] : 1'b0;
			if (blinking[ch]) begin
				if (blink_ticks[ch] != CNT_MAX) begin
					blink_ticks[ch]++;
				end
				if (blink_ticks[ch] % per == 0) begin
					led_on[ch] = ~led_on[ch];
				end
				if (blink_ticks[ch] >= duration_thr) begin
					blinking[ch] = 1'b0;
				end
			end else if (held) begin
				if (press_ticks[ch] != CNT_MAX) begin
					press_ticks[ch]++;
				end
			end else begin
				// Release: classify the hold time, the short test first.
				if (press_ticks[ch] >= short_thr) begin
					if (press_ticks[ch] < long_thr) begin
						led_on[ch] = ~led_on[ch];
					end else begin
						blinking[ch] = 1'b1;
						blink_ticks[ch] = '0;
					end
				end
				press_ticks[ch] = '0;
			end
			if (ch < BTN_W) begin
				r.leds[ch] = led_on[ch];
				r.blinks[ch] = blinking[ch];
			end
		end
		return r;
	endfunction

	// Button side: one beat per tick, with random bursts of idle cycles.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				mask_expect_q.push_back(predict_tick(button_levels));
			end
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if ($urandom_range(0, 99) < gap_pct) begin
					send_gap = $urandom_range(1, 12) - 1;
					in_valid <= 1'b0;
				end else if (tick_queue.size() != 0) begin
					in_valid <= 1'b1;
					button_levels <= tick_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// LED side: drive random out_stall bursts and compare each accepted beat with the oldest prediction.
	always @(posedge clk) begin
		tick_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (mask_expect_q.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual led %h blink %h",
						$time, led_levels, blink_active);
					mismatches++;
				end else begin
					want = mask_expect_q.pop_front();
					if (led_levels !== want.leds) begin
						$display("%0t: led_levels expected %h actual %h",
							$time, want.leds, led_levels);
						mismatches++;
					end
					if (blink_active !== want.blinks) begin
						$display("%0t: blink_active expected %h actual %h",
							$time, want.blinks, blink_active);
						mismatches++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(1, 12) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic cfg_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SHORT:    short_thr = value[CNT_W-1:0];
			REG_LONG:     long_thr = value[CNT_W-1:0];
			REG_PERIOD:   period_thr = value[CNT_W-1:0];
			REG_DURATION: duration_thr = value[CNT_W-1:0];
		endcase
	endtask

	task automatic set_thresholds(input int s, input int l, input int p, input int d);
		cfg_write(REG_SHORT, {16'($urandom), 16'(s)});
		cfg_write(REG_LONG, {16'($urandom), 16'(l)});
		cfg_write(REG_PERIOD, {16'($urandom), 16'(p)});
		cfg_write(REG_DURATION, {16'($urandom), 16'(d)});
	endtask

	task automatic random_small_thresholds();
		int s;
		s = $urandom_range(1, 6);
		set_thresholds(s, s + $urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(1, 40));
	endtask

	task automatic wait_drained();
		while (tick_queue.size() != 0 || in_valid || mask_expect_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_repeat(input logic [BTN_W-1:0] levels, input int n);
		repeat (n) tick_queue.push_back(levels);
	endtask

	// Hold lengths cluster around the thresholds to aim at every classification; holds over 60 are redrawn.
	function automatic int pick_hold();
		int s;
		int l;
		int len;
		s = short_thr;
		l = long_thr;
		case ($urandom_range(0, 6))
			0: len = s - 1;
			1: len = s;
			2: len = (l > s) ? $urandom_range(s, l - 1) : s;
			3: len = l - 1;
			4: len = l;
			5: len = l + $urandom_range(0, 5);
			default: len = $urandom_range(1, 3);
		endcase
		if (len > 60) begin
			len = $urandom_range(1, 60);
		end
		return (len < 0) ? 0 : len;
	endfunction

	task automatic queue_presses(input int n, input int noise_pct);
		logic [BTN_W-1:0] lv;
		repeat (n) begin
			lv = '0;
			for (int ch = 0; ch < BTN_W; ch++) begin
				if (hold_left[ch] == 0 && rest_left[ch] == 0) begin
					hold_left[ch] = pick_hold();
					rest_left[ch] = $urandom_range(1, 4);
				end
				if (hold_left[ch] > 0) begin
					lv[ch] = 1'b1;
					hold_left[ch]--;
				end else begin
					rest_left[ch]--;
				end
			end
			if ($urandom_range(0, 99) < noise_pct) begin
				lv = ($urandom_range(0, 1) == 0) ? lv ^ BTN_W'(1 << $urandom_range(0, 7))
					: BTN_W'($urandom);
			end
			tick_queue.push_back(lv);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset thresholds: a hold of five toggles, a hold of four does nothing.
		queue_repeat(8'h00, 1);
		queue_repeat(8'hFF, 6);
		queue_repeat(8'h00, 1);
		queue_repeat(8'h55, 5);
		queue_repeat(8'h00, 1);
		queue_repeat(8'hAA, 4);
		queue_repeat(8'h00, 1);
		wait_drained();

		// Long below short, blink period zero, blink duration zero after masking.
		cfg_write(REG_SHORT, 32'd2);
		cfg_write(REG_LONG, 32'd1);
		cfg_write(REG_PERIOD, 32'd0);
		cfg_write(REG_DURATION, 32'h0001_0000);
		queue_repeat(8'h0F, 2);
		queue_repeat(8'h00, 3);
		queue_repeat(8'hF0, 1);
		queue_repeat(8'h00, 2);
		wait_drained();

		// Short threshold zero: idle channels toggle every tick, then with long zero they start blinking.
		cfg_write(REG_SHORT, 32'hABCD_0000);
		cfg_write(REG_LONG, 32'd3);
		cfg_write(REG_PERIOD, 32'd2);
		cfg_write(REG_DURATION, 32'd4);
		queue_repeat(8'h00, 3);
		queue_repeat(8'hFF, 2);
		queue_repeat(8'h00, 1);
		queue_repeat(8'hFF, 3);
		queue_repeat(8'h00, 2);
		wait_drained();
		cfg_write(REG_LONG, 32'd0);
		queue_repeat(8'h00, 6);
		queue_repeat(8'h33, 2);
		wait_drained();

		gap_pct = 15;
		stall_pct = 15;
		set_thresholds(1, 2, 1, 1);
		queue_presses(140, 5);
		wait_drained();

		gap_pct = 30;
		stall_pct = 10;
		random_small_thresholds();
		queue_presses(140, 10);
		wait_drained();

		gap_pct = 5;
		stall_pct = 30;
		set_thresholds(65535, 65535, 65535, 65535);
		queue_presses(80, 10);
		wait_drained();

		gap_pct = 20;
		stall_pct = 20;
		random_small_thresholds();
		queue_presses(160, 20);
		wait_drained();

		gap_pct = 0;
		stall_pct = 0;
		random_small_thresholds();
		queue_presses(180, 5);
		wait_drained();
		repeat (20) @(posedge clk);

		if (mismatches == 0 && mask_expect_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
